### hdl/wsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Warp issue scheduler package
// Shared constants, payload types and the controller/datapath interface.
// ----------------------------------------------------------------------------
package wsu_pkg;

    localparam int WARP_COUNT_DEF = 8;
    localparam int MASK_BITS      = 8;
    localparam int WIDX_W         = 3;
    localparam int AGE_W          = 32;

    typedef struct packed {
        logic [MASK_BITS-1:0] active_mask;
        logic [MASK_BITS-1:0] stalled_mask;
    } t_sched_req;

    typedef struct packed {
        logic              warp_found;
        logic [WIDX_W-1:0] warp_index;
    } t_sched_rsp;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic finish_fast;
        logic finish_scan;
    } t_ctrl_cmd;

    typedef struct packed {
        logic fast_hit;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

### hdl/wsu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Warp issue scheduler datapath
// Policy register, request mask, warp ages, greedy state and result register.
// ----------------------------------------------------------------------------
module wsu_datapath #(
    parameter int WARP_COUNT = wsu_pkg::WARP_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  wsu_pkg::t_sched_req i_req,
    input  wsu_pkg::t_ctrl_cmd  i_cmd,
    input  logic               i_out_ready,
    output wsu_pkg::t_dp_status o_status,
    output logic               o_out_valid,
    output wsu_pkg::t_sched_rsp o_out_data
);
    import wsu_pkg::*;

    localparam int LANES = (WARP_COUNT < MASK_BITS) ? WARP_COUNT : MASK_BITS;
    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [MASK_BITS-1:0] LANE_MASK = {MASK_BITS{1'b1}} >> (MASK_BITS - LANES);

    logic                 r_mode;
    logic [MASK_BITS-1:0] r_ready;
    logic [AGE_W-1:0]     r_age [LANES];
    logic [IDX_W-1:0]     r_idx;
    logic [AGE_W-1:0]     r_best;
    logic [WIDX_W-1:0]    r_pick;
    logic                 r_found;
    logic                 r_greedy_valid;
    logic [WIDX_W-1:0]    r_greedy_warp;
    logic                 r_out_valid;
    t_sched_rsp           r_out_data;

    logic [WIDX_W-1:0] first_idx;
    logic              any_ready;
    logic              greedy_hit;
    logic [WIDX_W-1:0] scan_warp;
    logic              scan_ready;
    logic [AGE_W-1:0]  age_inc;
    logic              take;
    logic [IDX_W-1:0]  pick_slot;

    always_comb begin
        first_idx = '0;
        for (int w = MASK_BITS - 1; w >= 0; w--) begin
            if (r_ready[w]) begin
                first_idx = WIDX_W'(w);
            end
        end
    end

    assign any_ready  = |r_ready;
    assign greedy_hit = r_greedy_valid && r_ready[r_greedy_warp];
    assign scan_warp  = WIDX_W'(r_idx);
    assign scan_ready = r_ready[scan_warp];
    assign age_inc    = r_age[r_idx] + AGE_W'(1);
    assign take       = scan_ready && (age_inc >= r_best);
    assign pick_slot  = r_pick[IDX_W-1:0];

    assign o_status.fast_hit  = !r_mode || greedy_hit;
    assign o_status.scan_last = (r_idx == IDX_W'(LANES - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= 1'b0;
            r_greedy_valid <= 1'b0;
            r_greedy_warp  <= '0;
            r_out_valid    <= 1'b0;
            for (int w = 0; w < LANES; w++) begin
                r_age[w] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.scan_step && scan_ready) begin
                r_age[r_idx] <= age_inc;
            end
            if (i_cmd.finish_fast) begin
                r_out_valid <= 1'b1;
            end
            if (i_cmd.finish_scan) begin
                r_out_valid    <= 1'b1;
                r_greedy_valid <= r_found;
                if (r_found) begin
                    r_greedy_warp     <= r_pick;
                    r_age[pick_slot]  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ready <= i_req.active_mask & ~i_req.stalled_mask & LANE_MASK;
            r_idx   <= '0;
            r_best  <= '0;
            r_pick  <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (take) begin
                r_best  <= age_inc;
                r_pick  <= scan_warp;
                r_found <= 1'b1;
            end
        end
        if (i_cmd.finish_fast) begin
            if (r_mode) begin
                r_out_data.warp_found <= 1'b1;
                r_out_data.warp_index <= r_greedy_warp;
            end else begin
                r_out_data.warp_found <= any_ready;
                r_out_data.warp_index <= first_idx;
            end
        end
        if (i_cmd.finish_scan) begin
            r_out_data.warp_found <= r_found;
            r_out_data.warp_index <= r_found ? r_pick : '0;
        end
    end

endmodule

### hdl/wsu_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Warp issue scheduler controller
// Sequences request intake, the fast decision, the age sweep and the commit.
// ----------------------------------------------------------------------------
module wsu_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  wsu_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output wsu_pkg::t_ctrl_cmd  o_cmd
);
    import wsu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_status.fast_hit) begin
                    n_state = S_SCAN;
                end else if (i_status.out_free) begin
                    o_cmd.finish_fast = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.finish_scan = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/warp_issue_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Warp issue scheduler
// Picks one ready warp per request, lowest index first or greedy then oldest.
// ----------------------------------------------------------------------------
// One request is in work at a time. A request accepted in lowest-index mode,
// or in greedy-then-oldest mode while the greedy warp is still ready, is
// decided in the evaluate state and written to the result register, and the
// controller then returns to idle for the next request. Otherwise the ages of
// the first min(WARP_COUNT, 8) warps are swept by a single increment-and-compare
// unit, one warp per cycle, and the result is written in the commit state.
// A result still waiting in the result register holds the decision back until
// it is taken. The result register lets the next request be accepted while the
// previous result waits to be taken.
module warp_issue_scheduler_unit #(
    parameter int WARP_COUNT = wsu_pkg::WARP_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wsu_pkg::t_sched_req i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wsu_pkg::t_sched_rsp o_out_data
);
    import wsu_pkg::*;

    localparam int LANES = (WARP_COUNT < MASK_BITS) ? WARP_COUNT : MASK_BITS;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    wsu_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    wsu_datapath #(
        .WARP_COUNT (WARP_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input ready while a request is in work.");

    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("Result published with no request in work.");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.warp_found ? (32'(o_out_data.warp_index) < LANES)
                                               : (o_out_data.warp_index == '0)))
        else $error("Result index out of range.");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.scan_step, cmd.finish_fast, cmd.finish_scan}))
        else $error("Conflicting datapath commands.");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Warp issue scheduler testbench
// Sends scheduling requests through the valid/ready input channel under both
// policies. A scoreboard predicts each decision from its own copy of the
// greedy warp and the warp ages and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;

    import wsu_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 16;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 100;

    typedef enum logic {
        POLICY_LOWEST = 1'b0,
        POLICY_GTO    = 1'b1
    } t_policy;

    class sched_scoreboard;
        t_policy            policy = POLICY_LOWEST;
        logic               greedy_valid = 1'b0;
        logic [WIDX_W-1:0]  greedy_warp = '0;
        logic [AGE_W-1:0]   warp_age [WARP_COUNT_DEF];
        t_sched_rsp         decision_q [$];
        int                 errors = 0;
        int                 requests = 0;
        int                 gto_requests = 0;
        int                 greedy_reuses = 0;
        int                 idle_decisions = 0;
        int                 checked = 0;

        function new();
            foreach (warp_age[w]) warp_age[w] = '0;
        endfunction

        function void set_policy(logic p);
            policy = t_policy'(p);
        endfunction

        function int pending();
            return decision_q.size();
        endfunction

        function void note_request(t_sched_req req);
            logic [MASK_BITS-1:0] ready;
            logic [AGE_W-1:0]     best;
            t_sched_rsp           rsp;
            ready = req.active_mask & ~req.stalled_mask;
            rsp = '0;
            requests++;
            if (policy == POLICY_LOWEST) begin
                for (int w = 0; w < WARP_COUNT_DEF; w++) begin
                    if (ready[w] && !rsp.warp_found) begin
                        rsp.warp_found = 1'b1;
                        rsp.warp_index = WIDX_W'(w);
                    end
                end
            end else begin
                gto_requests++;
                if (greedy_valid && ready[greedy_warp]) begin
                    rsp.warp_found = 1'b1;
                    rsp.warp_index = greedy_warp;
                    greedy_reuses++;
                end else begin
                    greedy_valid = 1'b0;
                    best = '0;
                    for (int w = 0; w < WARP_COUNT_DEF; w++) begin
                        if (ready[w]) begin
                            warp_age[w] = warp_age[w] + 1'b1;
                            if (warp_age[w] >= best) begin
                                best = warp_age[w];
                                rsp.warp_found = 1'b1;
                                rsp.warp_index = WIDX_W'(w);
                            end
                        end
                    end
                    if (rsp.warp_found) begin
                        warp_age[rsp.warp_index] = '0;
                        greedy_valid = 1'b1;
                        greedy_warp = rsp.warp_index;
                    end
                end
            end
            if (!rsp.warp_found) idle_decisions++;
            decision_q.push_back(rsp);
        endfunction

        function void check_result(t_sched_rsp rsp);
            t_sched_rsp exp_rsp;
            if (decision_q.size() == 0) begin
                $error("Unexpected result: warp_found=%0d warp_index=%0d",
                       rsp.warp_found, rsp.warp_index);
                errors++;
                return;
            end
            exp_rsp = decision_q.pop_front();
            checked++;
            if (rsp.warp_found !== exp_rsp.warp_found) begin
                $error("warp_found mismatch: expected %0d, actual %0d",
                       exp_rsp.warp_found, rsp.warp_found);
                errors++;
            end
            if (rsp.warp_index !== exp_rsp.warp_index) begin
                $error("warp_index mismatch: expected %0d, actual %0d",
                       exp_rsp.warp_index, rsp.warp_index);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_sched_req in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_sched_rsp out_data;

    sched_scoreboard sb = new();

    int  cycle_cnt = 0;
    int  hold_req = 0;
    int  hold_ack = 0;
    int  rx_stall = 0;
    bit  rx_quiet = 1'b0;
    bit  tx_quiet = 1'b0;

    warp_issue_scheduler_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 4);
    endfunction

    // Result side: random stalls, quiet stretches and an occasional long hold.
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            rx_stall = LONG_HOLD;
            out_ready <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall--;
            out_ready <= 1'b0;
        end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
            rx_stall = idle_len() - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) sb.set_policy(cfg_wdata);
            if (out_valid && out_ready) sb.check_result(out_data);
            if (in_valid && in_ready) sb.note_request(in_data);
        end
    end

    task automatic send_req(t_sched_req req, int gap);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pair(logic [15:0] masks);
        t_sched_req req;
        req.active_mask  = masks[15:8];
        req.stalled_mask = masks[7:0];
        send_req(req, $urandom_range(0, 1));
    endtask

    task automatic wait_drained(int extra);
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_policy(t_policy p);
        wait_drained(DRAIN_WAIT);
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_sched_req random_req();
        t_sched_req          req;
        logic [MASK_BITS-1:0] one;
        one = MASK_BITS'(1) << $urandom_range(0, MASK_BITS - 1);
        case ($urandom_range(0, 9))
            0: begin
                req.active_mask  = MASK_BITS'($urandom());
                req.stalled_mask = MASK_BITS'($urandom());
            end
            1: begin
                req.active_mask  = '1;
                req.stalled_mask = MASK_BITS'($urandom());
            end
            2, 3, 4, 5: begin
                req.active_mask  = MASK_BITS'($urandom() | $urandom());
                req.stalled_mask = $urandom_range(0, 1) ? one : '0;
            end
            6: begin
                req.active_mask  = MASK_BITS'($urandom());
                req.stalled_mask = req.active_mask;
            end
            7: begin
                req.active_mask  = one | MASK_BITS'($urandom());
                req.stalled_mask = ~one;
            end
            default: begin
                // Stall the greedy warp so that the oldest-first search runs.
                req.active_mask  = MASK_BITS'($urandom() | $urandom());
                req.stalled_mask = MASK_BITS'(1) << sb.greedy_warp;
            end
        endcase
        return req;
    endfunction

    initial begin
        t_policy phase_policy;
        int      gap;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lowest-index policy straight after reset.
        send_pair(16'h0000);
        send_pair(16'hFF00);
        send_pair(16'hFFFF);
        send_pair(16'h8000);
        send_pair(16'hFF7F);
        send_pair(16'h0100);
        send_pair(16'hAA55);
        send_pair(16'h00FF);

        write_policy(POLICY_GTO);
        send_pair(16'hFF00);
        send_pair(16'hFF00);
        send_pair(16'hFF80);
        send_pair(16'h0000);
        send_pair(16'h4000);
        send_pair(16'h0101);
        send_pair(16'h0F00);
        send_pair(16'h0F00);
        send_pair(16'h0F01);
        send_pair(16'hF00F);
        send_pair(16'hFF00);
        send_pair(16'hFFFF);

        write_policy(POLICY_LOWEST);
        send_pair(16'h5500);
        send_pair(16'hFFFE);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) phase_policy = POLICY_GTO;
            else if (p == 1) phase_policy = POLICY_LOWEST;
            else phase_policy = t_policy'($urandom_range(0, 1));
            write_policy(phase_policy);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ((p == 2 || p == 7) && k == 30) begin
                    tx_quiet = 1'b1;
                    hold_req++;
                end
                if ((p == 4 && k == 60) || $urandom_range(0, 99) == 0) begin
                    wait_drained(0);
                end
                gap = (tx_quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
                send_req(random_req(), gap);
            end
        end

        wait_drained(DRAIN_WAIT);
        $display("Checked %0d of %0d requests; %0d in greedy-then-oldest mode.",
                 sb.checked, sb.requests, sb.gto_requests);
        $display("Greedy warp reused %0d times; %0d requests found no ready warp.",
                 sb.greedy_reuses, sb.idle_decisions);
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hdl/wsu_pkg.sv
hdl/wsu_datapath.sv
hdl/wsu_controller.sv
hdl/warp_issue_scheduler_unit.sv
tb/sv/tb_top.sv
